/* rtl/core/tscd_pkg.sv */
package tscd_pkg;

    localparam int Capacity = 64;
    localparam int SlotW = $clog2(Capacity);
    localparam int CountW = SlotW + 1;
    localparam int IdBytes = 32;

    localparam logic [30:0] ResetTimeout = 31'd86400;
    localparam logic [6:0] ResetMaxEntries = 7'd50;

    localparam logic [0:0] RegTimeout = 1'b0;
    localparam logic [0:0] RegMaxEntries = 1'b1;

    localparam logic FuncGet = 1'b0;
    localparam logic FuncSet = 1'b1;

    typedef struct packed {
        logic        func;
        logic [63:0] id_word0;
        logic [63:0] id_word1;
        logic [63:0] id_word2;
        logic [63:0] id_word3;
        logic [5:0]  id_length;
        logic [15:0] suite;
        logic [7:0]  compression_method;
        logic [31:0] verify_in;
        logic [31:0] now_seconds;
    } req_t;

    typedef struct packed {
        logic        status;
        logic [5:0]  slot;
        logic [31:0] verify_out;
    } rsp_t;

    // One directory entry as held in the slot memory.
    typedef struct packed {
        logic [255:0] id;
        logic [5:0]   id_length;
        logic [15:0]  suite;
        logic [7:0]   compression;
        logic [31:0]  stamp;
        logic [31:0]  verify;
    } entry_t;

    // Mask of the first n id bytes, byte 0 in the top bits.
    function automatic logic [255:0] prefix_mask(input logic [5:0] n);
        logic [255:0] m;
        logic [5:0]   lim;
        begin
            lim = (n > 6'(IdBytes)) ? 6'(IdBytes) : n;
            for (int b = 0; b < 32; b++)
            begin
                m[255 - 8*b -: 8] = (6'(b) < lim) ? 8'hFF : 8'h00;
            end
            return m;
        end
    endfunction

endpackage

/* rtl/core/tls_session_cache_directory_core.sv */
// Scan: a get stops at the first hit and a miss scans every used slot; a set stops at the first
// slot with a matching id prefix or an expired entry, and otherwise scans every used slot.
// One request at a time; the scan reads the slot memory one entry per READ and CHECK pass.
// A finished result waits in the output register, so the next request can start meanwhile.
// Reset: clears the used-slot count and restores the timeout and the entry limit to their
// defaults. Slot contents are left as they are, being read only after being written.
module tls_session_cache_directory_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tscd_pkg::req_t      in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tscd_pkg::rsp_t      out_data,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [30:0]         cfg_wdata
);

    localparam int SW = tscd_pkg::SlotW;
    localparam int CW = tscd_pkg::CountW;

    typedef enum logic [2:0] {IDLE, READ, CHECK, FINISH, WRITE, RESP} state_t;

    state_t             state_reg;
    tscd_pkg::req_t     req_reg;
    logic [30:0]        timeout_reg;
    logic [6:0]         max_reg;
    logic [CW-1:0]      used_reg;
    logic [CW-1:0]      lim_reg;
    logic [CW-1:0]      idx_reg;
    logic               old_valid_reg;
    logic [31:0]        oldest_reg;
    logic [SW-1:0]      old_reg;
    logic [SW-1:0]      target_reg;
    logic               keep_time_reg;
    tscd_pkg::entry_t   keep_entry_reg;
    tscd_pkg::rsp_t     res_reg;
    logic               out_valid_reg;
    tscd_pkg::rsp_t     out_reg;

    tscd_pkg::entry_t   rd;
    tscd_pkg::entry_t   wdata;
    logic               we;
    logic [SW-1:0]      raddr;
    logic [255:0]       req_id;
    logic [31:0]        age;
    logic               expired;
    logic               prefix_ok;
    logic               get_hit;

    assign req_id = {req_reg.id_word0, req_reg.id_word1, req_reg.id_word2, req_reg.id_word3};
    assign raddr = idx_reg[SW-1:0];

    assign age = req_reg.now_seconds - rd.stamp;
    assign expired = (timeout_reg != 31'd0) && !age[31] && (age[30:0] > timeout_reg);
    assign prefix_ok = (((rd.id ^ req_id) & tscd_pkg::prefix_mask(rd.id_length)) == '0);
    assign get_hit = !expired && prefix_ok && rd.suite == req_reg.suite
                     && rd.compression == req_reg.compression_method
                     && rd.id_length == req_reg.id_length;

    assign we = (state_reg == WRITE);
    always_comb
    begin
        wdata.id = req_id;
        wdata.id_length = req_reg.id_length;
        wdata.suite = req_reg.suite;
        wdata.compression = req_reg.compression_method;
        wdata.verify = req_reg.verify_in;
        wdata.stamp = keep_time_reg ? keep_entry_reg.stamp : req_reg.now_seconds;
    end

    tscd_slot_ram u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (target_reg),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd)
    );

    assign in_ready = (state_reg == IDLE);
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            req_reg <= '0;
            timeout_reg <= tscd_pkg::ResetTimeout;
            max_reg <= tscd_pkg::ResetMaxEntries;
            used_reg <= '0;
            out_valid_reg <= 1'b0;
            out_reg <= '0;
            res_reg <= '0;
            idx_reg <= '0;
            lim_reg <= '0;
            old_valid_reg <= 1'b0;
            oldest_reg <= '0;
            old_reg <= '0;
            target_reg <= '0;
            keep_time_reg <= 1'b0;
            keep_entry_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tscd_pkg::RegTimeout:    timeout_reg <= cfg_wdata;
                    tscd_pkg::RegMaxEntries: max_reg <= cfg_wdata[6:0];
                    default: ;
                endcase
            end
            if (out_valid_reg && out_ready && state_reg != RESP)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        req_reg <= in_data;
                        idx_reg <= '0;
                        lim_reg <= used_reg;
                        old_valid_reg <= 1'b0;
                        keep_time_reg <= 1'b0;
                        state_reg <= (used_reg == '0) ? FINISH : READ;
                    end
                end
                READ:
                begin
                    state_reg <= CHECK;
                end
                CHECK:
                begin
                    if (req_reg.func == tscd_pkg::FuncGet)
                    begin
                        if (get_hit)
                        begin
                            res_reg <= '{status: 1'b0, slot: 6'(idx_reg[SW-1:0]),
                                         verify_out: rd.verify};
                            state_reg <= RESP;
                        end
                        else if (idx_reg + 1'b1 == lim_reg)
                        begin
                            state_reg <= FINISH;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                            state_reg <= READ;
                        end
                    end
                    else if (expired || prefix_ok)
                    begin
                        target_reg <= idx_reg[SW-1:0];
                        keep_time_reg <= !expired;
                        keep_entry_reg <= rd;
                        state_reg <= WRITE;
                    end
                    else
                    begin
                        if (!old_valid_reg || rd.stamp < oldest_reg)
                        begin
                            old_valid_reg <= 1'b1;
                            oldest_reg <= rd.stamp;
                            old_reg <= idx_reg[SW-1:0];
                        end
                        if (idx_reg + 1'b1 == lim_reg)
                        begin
                            state_reg <= FINISH;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                            state_reg <= READ;
                        end
                    end
                end
                FINISH:
                begin
                    if (req_reg.func == tscd_pkg::FuncGet)
                    begin
                        res_reg <= '{status: 1'b1, slot: 6'd0, verify_out: 32'd0};
                        state_reg <= RESP;
                    end
                    else if ({1'b0, lim_reg} >= {1'b0, max_reg}
                             || lim_reg >= CW'(tscd_pkg::Capacity))
                    begin
                        if (old_valid_reg)
                        begin
                            target_reg <= old_reg;
                            state_reg <= WRITE;
                        end
                        else
                        begin
                            res_reg <= '{status: 1'b1, slot: 6'd0, verify_out: 32'd0};
                            state_reg <= RESP;
                        end
                    end
                    else
                    begin
                        target_reg <= lim_reg[SW-1:0];
                        used_reg <= lim_reg + 1'b1;
                        state_reg <= WRITE;
                    end
                end
                WRITE:
                begin
                    res_reg <= '{status: 1'b0, slot: 6'(target_reg), verify_out: 32'd0};
                    state_reg <= RESP;
                end
                RESP:
                begin
                    // The result moves on once the previous transfer has left the output.
                    if (!out_valid_reg || out_ready)
                    begin
                        out_reg <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(tscd_pkg::Capacity))
        else $error("used slot count above capacity");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while busy");

    a_used_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != $past(used_reg)) |-> (used_reg == $past(used_reg) + 1'b1))
        else $error("used slot count changed by other than one");

endmodule

/* rtl/core/tscd_slot_ram.sv */
module tscd_slot_ram (
    input  logic                            clk,
    input  logic                            we,
    input  logic [tscd_pkg::SlotW-1:0]      waddr,
    input  tscd_pkg::entry_t                wdata,
    input  logic [tscd_pkg::SlotW-1:0]      raddr,
    output tscd_pkg::entry_t                rdata
);

    tscd_pkg::entry_t mem [tscd_pkg::Capacity];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
